// File: rtl/rwa_pkg.sv
// Shared types and constants for the ring-window average / lag difference block.
// No dependencies.
package rwa_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int LEN_W     = 7;
    localparam int LAG_W     = 6;
    localparam int SUM_W     = 23;  // 127 entries of 16 bits, signed
    localparam int MAG_W     = 22;  // magnitude of the sum
    localparam int DIV_CNT_W = 5;   // holds MAG_W
    localparam int MAX_LEN   = 127; // largest length the register can name

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic        [LAG_W-1:0]    lag;
    } rwa_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic signed [SAMPLE_W-1:0] difference;
    } rwa_out_t;

    // controller -> datapath
    typedef struct packed {
        logic clear_wr;
        logic sum_start;
        logic sum_step;
        logic accept;
        logic old_step;
        logic lag_step;
        logic out_load;
    } rwa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic sum_done;
        logic div_done;
        logic out_free;
    } rwa_stat_t;

endpackage

// File: rtl/rwa_div.sv
// Serial signed divider: window sum / length, truncated toward zero, one bit per cycle.
// Depends on rwa_pkg.
module rwa_div import rwa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [SUM_W-1:0]  dividend,
    input  logic        [LEN_W-1:0]  divisor,
    output logic                     done,
    output logic        [SAMPLE_W-1:0] quotient
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic [MAG_W-1:0]     quo_reg, quo_next;
    logic [LEN_W-1:0]     dvs_reg;
    logic                 neg_reg;
    logic [SUM_W-1:0]     mag;
    logic [LEN_W:0]       rem_sh;
    logic [LEN_W:0]       rem_sub;
    logic                 ge;

    always_comb
    begin
        mag      = dividend[SUM_W-1] ? (SUM_W)'(-dividend) : dividend;
        rem_sh   = {rem_reg, quo_reg[MAG_W-1]};
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(MAG_W);
            rem_next = '0;
            quo_next = mag[MAG_W-1:0];
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
            quo_next = {quo_reg[MAG_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
    end

    assign done     = (cnt_reg == '0);
    // |quotient| tops out at 32768 for a negative sum, which negates to 0x8000
    assign quotient = neg_reg ? SAMPLE_W'(-quo_reg[SAMPLE_W-1:0]) : quo_reg[SAMPLE_W-1:0];

endmodule

// File: rtl/rwa_dp.sv
// Datapath: sample store, running window sum, positions, output register.
// Depends on rwa_pkg and rwa_div.
module rwa_dp import rwa_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  rwa_cmd_t         cmd,
    output rwa_stat_t        st,
    input  rwa_in_t          in_data,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,
    output logic             out_valid,
    input  logic             out_stall,
    output rwa_out_t         out_data
);

    localparam int AW     = $clog2(DEPTH);
    localparam int IW     = (AW > LEN_W) ? AW : LEN_W;
    localparam int MAXLEN = (DEPTH < MAX_LEN) ? DEPTH : MAX_LEN;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic                wr_en;

    logic [LEN_W-1:0]      len_reg, len_next;
    logic [IW-1:0]         pos_reg, pos_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                  out_valid_reg, out_valid_next;

    logic [SAMPLE_W-1:0] sample_reg;
    logic [IW-1:0]       newest_reg;
    logic [IW-1:0]       older_reg;
    logic                zero_lag_reg;
    logic [SAMPLE_W-1:0] diff_reg;
    rwa_out_t            out_data_reg;

    logic [LEN_W-1:0] eff7;
    logic [IW-1:0]    effx;
    logic [IW-1:0]    newest_c;
    logic [IW-1:0]    inc_c;
    logic [IW-1:0]    lag_x;
    logic [IW-1:0]    lag_s;
    logic [IW-1:0]    older_c;

    logic                div_done;
    logic [SAMPLE_W-1:0] div_q;

    // effective length: zero acts as one, clamp to the store depth
    always_comb
    begin
        eff7 = len_reg;
        if (len_reg == '0)
        begin
            eff7 = LEN_W'(1);
        end
        else if (IW'(len_reg) > IW'(MAXLEN))
        begin
            eff7 = LEN_W'(MAXLEN);
        end
        effx = IW'(eff7);
    end

    always_comb
    begin
        newest_c = (pos_reg >= effx) ? '0 : pos_reg;
        inc_c    = newest_c + 1'b1;
        lag_x    = IW'(in_data.lag);
        lag_s    = (lag_x > effx - 1'b1) ? effx - 1'b1 : lag_x;
        older_c  = (newest_c >= lag_s) ? newest_c - lag_s : newest_c + effx - lag_s;
    end

    // store port muxing
    always_comb
    begin
        rd_addr = idx_reg[AW-1:0];
        if (cmd.accept)
        begin
            rd_addr = newest_c[AW-1:0];
        end
        else if (cmd.old_step)
        begin
            rd_addr = older_reg[AW-1:0];
        end
        wr_en   = cmd.clear_wr | cmd.old_step;
        wr_addr = cmd.old_step ? newest_reg[AW-1:0] : idx_reg[AW-1:0];
        wr_data = cmd.old_step ? sample_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        len_next       = len_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cfg_we)
        begin
            len_next = cfg_wdata;
            pos_next = '0;
        end
        else if (cmd.accept)
        begin
            pos_next = (inc_c >= effx) ? '0 : inc_c;
        end

        if (cmd.sum_start)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
            sum_next  = '0;
        end
        else if (cmd.clear_wr)
        begin
            idx_next = st.clear_last ? '0 : idx_reg + 1'b1;
        end
        else if (cmd.sum_step)
        begin
            if (pend_reg)
            begin
                sum_next = sum_reg + SUM_W'(signed'(rdata_reg));
            end
            if (idx_reg < effx)
            begin
                idx_next  = idx_reg + 1'b1;
                pend_next = 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
            end
        end
        else if (cmd.old_step)
        begin
            // replace the overwritten entry's contribution
            sum_next = sum_reg + SUM_W'(signed'(sample_reg)) - SUM_W'(signed'(rdata_reg));
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_RESET;
            pos_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg   <= in_data.sample;
            newest_reg   <= newest_c;
            older_reg    <= older_c;
            zero_lag_reg <= (lag_s == '0);
        end
        if (cmd.lag_step)
        begin
            diff_reg <= zero_lag_reg ? '0 : sample_reg - rdata_reg;
        end
        if (cmd.out_load)
        begin
            out_data_reg.average    <= div_q;
            out_data_reg.difference <= diff_reg;
        end
    end

    rwa_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.lag_step),
        .dividend (sum_next),
        .divisor  (eff7),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        st.clear_last = (idx_reg == IW'(DEPTH - 1));
        st.sum_done   = (idx_reg >= effx) && !pend_reg;
        st.div_done   = div_done;
        st.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < effx)
        else $error("write position outside window");

    a_sum_idle_on_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !pend_reg)
        else $error("item accepted during sum rebuild");

endmodule

// File: rtl/rwa_ctrl.sv
// Controller FSM: clearing pass, sum rebuild, per-request sequencing.
// Depends on rwa_pkg.
module rwa_ctrl import rwa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic      cfg_we,
    input  rwa_stat_t st,
    output rwa_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SUM,
        S_OLD,
        S_LAG,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (st.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    cmd.sum_start = 1'b1;
                    state_next    = S_SUM;
                end
                else if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_OLD;
                end
            end
            S_SUM:
            begin
                if (cfg_we)
                begin
                    cmd.sum_start = 1'b1;
                end
                else if (st.sum_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.sum_step = 1'b1;
                end
            end
            S_OLD:
            begin
                cmd.old_step = 1'b1;
                state_next   = S_LAG;
            end
            S_LAG:
            begin
                cmd.lag_step = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE) || cfg_we;

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> st.out_free)
        else $error("output register overwritten");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_CLEAR |=> state_reg != S_CLEAR)
        else $error("clearing pass re-entered");

    a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lag_step |=> !st.div_done)
        else $error("divider did not start");

endmodule

// File: rtl/ring_window_average_and_lag_difference.sv
// Top level: ring-window moving average with lag difference.
// Depends on rwa_pkg, rwa_ctrl, rwa_dp (which holds rwa_div).
//
// Usage
//   Input channel (in_valid / in_stall / in_data): one request carries a signed
//   sample and a lag. The sample goes into the circular window at the write
//   position, the position advances and wraps at the window length.
//   Output channel (out_valid / out_stall / out_data): one result per request,
//   the window mean (sum / length, truncated toward zero) and newest minus the
//   sample lag steps back, wrapped to 16 bits. Lag saturates at length-1.
//   Config: cfg_we / cfg_wdata writes the window length (0 acts as 1, values
//   above DEPTH act as DEPTH) and sends the write position back to zero.
// Sequencing
//   One request in flight at a time: after acceptance it passes the store read
//   and sum update, the 22-step serial divider and the output register load.
//   The next request can be accepted in the cycle after the result is loaded into
//   the output register, not before, so a new request is not taken while the
//   last one is still being worked on.
//   A length write rebuilds the window sum from the store, with in_stall high
//   meanwhile.
// Reset
//   After rst_n the store is cleared one entry a cycle, with in_stall high.
//   A stalled result stays in the output register; the next request may
//   still be worked on and waits in the controller until it frees.
module ring_window_average_and_lag_difference import rwa_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rwa_in_t          in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output rwa_out_t         out_data,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata
);

    rwa_cmd_t  cmd;
    rwa_stat_t st;

    // sequencing only; all storage and arithmetic sit in the datapath
    rwa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cfg_we   (cfg_we),
        .st       (st),
        .cmd      (cmd)
    );

    rwa_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
